// ----- rtl/kgr_pkg.sv -----
// kgr_pkg: shared constants, payload structs and state type for the k-group reverser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package kgr_pkg;

    // chain length, i.e. largest group that can be reversed
    localparam int MAX_GROUP = 16;
    localparam int DATA_W    = 32;
    localparam int GS_W      = 5;
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);

    // input transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] elem_value;
        logic                     list_end;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic                     run_last;
        logic                     list_done;
    } t_out_item;

    // shift commands broadcast to every cell of the chain
    typedef struct packed {
        logic shr;   // take the left neighbor's contents
        logic shl;   // take the right neighbor's contents
    } t_cell_ctl;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REV,
        ST_FWD
    } t_state;

endpackage

// ----- rtl/kgr_cell.sv -----
// kgr_cell: one storage cell of the element chain, shifts left or right on command
// depends on kgr_pkg
`timescale 1ns / 1ps

module kgr_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kgr_pkg::t_cell_ctl                i_ctl,
    input  logic signed [kgr_pkg::DATA_W-1:0] i_left_data,
    input  logic                              i_left_vld,
    input  logic signed [kgr_pkg::DATA_W-1:0] i_right_data,
    input  logic                              i_right_vld,
    output logic signed [kgr_pkg::DATA_W-1:0] o_data,
    output logic                              o_vld
);
    import kgr_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic                     r_vld;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.shr) begin
            r_vld <= i_left_vld;
        end else if (i_ctl.shl) begin
            r_vld <= i_right_vld;
        end
    end

    // element value
    always_ff @(posedge i_clk) begin
        if (i_ctl.shr) begin
            r_data <= i_left_data;
        end else if (i_ctl.shl) begin
            r_data <= i_right_data;
        end
    end

    assign o_data = r_data;
    assign o_vld  = r_vld;

endmodule

// ----- rtl/k_group_reverser.sv -----
// k_group_reverser: top level, sequencer, output register and the chain of kgr_cell
// depends on kgr_pkg and kgr_cell
`timescale 1ns / 1ps

// Elements enter at cell 0 of a chain of MAX_GROUP cells and push the held ones one
// cell further. An element that neither completes a group nor ends the list leaves the
// block idle for the next one. When a group of n elements is complete, the chain shifts
// back toward cell 0 and emits one element per cycle while the output is not stalled,
// newest first. When the list ends before the group is full, the chain shifts toward
// its far end and emits from the last cell in arrival order, as every element must
// travel the whole chain. Both ends of the chain feed a single output register, so
// at most one result leaves per cycle; the input is taken only while no group is
// draining. The user must write group_size on the configuration channel only while
// the block is idle; the block does not enforce this. Values 0 and 1 pass each element
// through, values above MAX_GROUP act as MAX_GROUP.

module k_group_reverser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [kgr_pkg::GS_W-1:0]  i_cfg_data,
    // element input
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  kgr_pkg::t_in_item         i_in,
    // result output
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output kgr_pkg::t_out_item        o_out
);
    import kgr_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_GROUP);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    t_state            r_state, n_state;
    logic [GS_W-1:0]   r_group_size;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_end, n_end;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    t_cell_ctl                cell_ctl;
    logic signed [DATA_W-1:0] cell_data [MAX_GROUP];
    logic                     cell_vld  [MAX_GROUP];

    logic             in_take;
    logic             out_free;
    logic [CNT_W-1:0] group_k;
    logic [CNT_W-1:0] fill;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GS_W'(2);
        end else if (i_cfg_valid) begin
            r_group_size <= i_cfg_data;
        end
    end

    // effective group length
    always_comb begin
        if (r_group_size < GS_W'(2)) begin
            group_k = ONE_CNT;
        end else if (int'(r_group_size) > MAX_GROUP) begin
            group_k = MAX_CNT;
        end else begin
            group_k = CNT_W'(r_group_size);
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_take    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign fill       = r_count + ONE_CNT;

    // sequencer: next state, chain shifts and output loading
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_end        = r_end;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        cell_ctl.shr = 1'b0;
        cell_ctl.shl = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    cell_ctl.shr = 1'b1;
                    n_count      = fill;
                    n_end        = i_in.list_end;
                    if (fill >= group_k) begin
                        n_state = ST_REV;
                    end else if (i_in.list_end) begin
                        n_state = ST_FWD;
                    end
                end
            end
            ST_REV: begin
                // newest element sits in cell 0
                if (out_free) begin
                    cell_ctl.shl        = 1'b1;
                    n_out_valid         = 1'b1;
                    n_out.out_value     = cell_data[0];
                    n_out.run_last      = (r_count == ONE_CNT);
                    n_out.list_done     = (r_count == ONE_CNT) && r_end;
                    n_count             = r_count - ONE_CNT;
                    if (r_count == ONE_CNT) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FWD: begin
                // oldest element reaches the far end first
                if (!cell_vld[MAX_GROUP-1]) begin
                    cell_ctl.shr = 1'b1;
                end else if (out_free) begin
                    cell_ctl.shr        = 1'b1;
                    n_out_valid         = 1'b1;
                    n_out.out_value     = cell_data[MAX_GROUP-1];
                    n_out.run_last      = (r_count == ONE_CNT);
                    n_out.list_done     = (r_count == ONE_CNT);
                    n_count             = r_count - ONE_CNT;
                    if (r_count == ONE_CNT) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // chain of cells, cell 0 takes the incoming element
    for (genvar gi = 0; gi < MAX_GROUP; gi++) begin : g_cell
        logic signed [DATA_W-1:0] left_data, right_data;
        logic                     left_vld, right_vld;

        if (gi == 0) begin : g_head
            assign left_data = i_in.elem_value;
            assign left_vld  = in_take;
        end else begin : g_body
            assign left_data = cell_data[gi-1];
            assign left_vld  = cell_vld[gi-1];
        end

        if (gi == MAX_GROUP - 1) begin : g_tail
            assign right_data = cell_data[gi];
            assign right_vld  = 1'b0;
        end else begin : g_inner
            assign right_data = cell_data[gi+1];
            assign right_vld  = cell_vld[gi+1];
        end

        kgr_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_left_data  (left_data),
            .i_left_vld   (left_vld),
            .i_right_data (right_data),
            .i_right_vld  (right_vld),
            .o_data       (cell_data[gi]),
            .o_vld        (cell_vld[gi])
        );
    end

endmodule

// ----- rtl/kgr_checker.sv -----
// kgr_checker: port-level assertions for the k-group reverser, bound to the top level
// depends on kgr_pkg and k_group_reverser
`timescale 1ns / 1ps

module kgr_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic                      o_cfg_ready,
    input  logic [kgr_pkg::GS_W-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      o_in_ready,
    input  kgr_pkg::t_in_item         i_in,
    input  logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  kgr_pkg::t_out_item        o_out
);
    import kgr_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // end of list is only flagged on the last result of its run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out.list_done || o_out.run_last))
        else $error("list_done without run_last");

    // the last element of a list always starts a drain
    a_end_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.list_end |=> !o_in_ready)
        else $error("input taken right after end of list");

    // while a run is unfinished no new element is taken
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.run_last |-> !o_in_ready)
        else $error("input ready in the middle of a run");

endmodule

bind k_group_reverser kgr_checker u_kgr_checker (.*);
